// File: hdl/cfrf_pkg.sv
package cfrf_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int MAX_PARAMS  = 16;
    localparam int FRAME_BYTES = MAX_PARAMS + 2;
    localparam int STORE_BYTES = QUEUE_DEPTH * FRAME_BYTES;

    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int COUNT_W = $clog2(FRAME_BYTES);
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    localparam int IDX_W   = 5;
    localparam int STAT_W  = 2;

    localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_START_BYTE = '0;

    typedef enum logic [OP_W-1:0] {
        OP_RECEIVE = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_EMPTY = 2'd0,
        ST_DATA  = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_CMD,
        RX_LEN,
        RX_PARAM
    } rx_state_t;

    // per-transaction result info travelling from control to the output stage
    typedef struct packed {
        logic    rd_use;
        status_t status;
        logic    queued;
        logic    dropped;
        logic    lerr;
    } meta_t;

endpackage

// File: hdl/cfrf_if.sv
interface cfrf_in_if;
    logic                              valid;
    logic                              ready;
    logic [cfrf_pkg::OP_W-1:0]         op;
    logic [cfrf_pkg::BYTE_W-1:0]       rx_byte;
    logic [cfrf_pkg::IDX_W-1:0]        byte_index;

    modport source (output valid, output op, output rx_byte, output byte_index,
                    input ready);
    modport sink   (input valid, input op, input rx_byte, input byte_index,
                    output ready);
endinterface

interface cfrf_out_if;
    logic                              valid;
    logic                              ready;
    logic [cfrf_pkg::BYTE_W-1:0]       read_data;
    logic [cfrf_pkg::STAT_W-1:0]       queue_status;
    logic                              frame_queued;
    logic                              frame_dropped;
    logic                              length_error;

    modport source (output valid, output read_data, output queue_status,
                    output frame_queued, output frame_dropped, output length_error,
                    input ready);
    modport sink   (input valid, input read_data, input queue_status,
                    input frame_queued, input frame_dropped, input length_error,
                    output ready);
endinterface

// File: hdl/command_frame_receiver_fifo_core.sv
// Path: stage 1, then the output register. Throughput: one transaction per
//   cycle unless result.ready stalls it; the frame store's single write port
//   and single registered read port each serve one access per transaction.
// Reset: rst_n is asynchronous, active low; it empties the queue, returns the
//   receiver to hunting and sets start_byte to 0xAA. Frame store is not cleared.
module command_frame_receiver_fifo_core (
    input  logic                                clk,
    input  logic                                rst_n,
    cfrf_in_if.sink                             item,
    cfrf_out_if.source                          result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfrf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cfrf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cfrf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    // Structure:
    //   cfrf_apb_regs    - start_byte register behind the APB port
    //   cfrf_ctrl        - receive FSM, head/tail slot pointers, store addressing
    //   cfrf_frame_store - QUEUE_DEPTH x FRAME_BYTES byte memory, registered read
    //   cfrf_out_stage   - read-data stage plus output register
    //
    // Frames are assembled directly in the tail slot. The tail slot is never
    // readable (reads only hit the head slot of a non-empty queue), so a write
    // and a read in the same cycle never touch the same entry, and a read in
    // the cycle after a write sees the written byte.

    logic [cfrf_pkg::BYTE_W-1:0]    start_byte;
    logic                           acc;
    logic                           in_ready;
    logic                           wr_en, rd_en;
    logic [cfrf_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
    logic [cfrf_pkg::BYTE_W-1:0]    rd_data;
    cfrf_pkg::meta_t                meta;

    assign item.ready = in_ready;
    assign acc        = item.valid && in_ready;

    cfrf_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start_byte (start_byte)
    );

    cfrf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .op         (item.op),
        .rx_byte    (item.rx_byte),
        .byte_index (item.byte_index),
        .start_byte (start_byte),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .meta       (meta)
    );

    // written byte is the received byte itself
    cfrf_frame_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cfrf_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .acc      (acc),
        .meta     (meta),
        .rd_data  (rd_data),
        .in_ready (in_ready),
        .result   (result)
    );

endmodule

// File: hdl/cfrf_apb_regs.sv
module cfrf_apb_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cfrf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cfrf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cfrf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [cfrf_pkg::BYTE_W-1:0]         start_byte
);

    logic [cfrf_pkg::BYTE_W-1:0] start_byte_reg;
    logic                        hit;

    // low two address bits are the byte lane, ignored
    assign hit    = (paddr[cfrf_pkg::APB_ADDR_W-1:2] == cfrf_pkg::REG_START_BYTE);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= cfrf_pkg::START_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            start_byte_reg <= pwdata[cfrf_pkg::BYTE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (hit)
        begin
            prdata[cfrf_pkg::BYTE_W-1:0] = start_byte_reg;
        end
    end

    assign start_byte = start_byte_reg;

endmodule

// File: hdl/cfrf_frame_store.sv
module cfrf_frame_store (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [cfrf_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [cfrf_pkg::BYTE_W-1:0]     wr_data,
    input  logic                            rd_en,
    input  logic [cfrf_pkg::ADDR_W-1:0]     rd_addr,
    output logic [cfrf_pkg::BYTE_W-1:0]     rd_data
);

    logic [cfrf_pkg::BYTE_W-1:0] mem [cfrf_pkg::STORE_BYTES];
    logic [cfrf_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/cfrf_ctrl.sv
module cfrf_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            acc,
    input  logic [cfrf_pkg::OP_W-1:0]       op,
    input  logic [cfrf_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [cfrf_pkg::IDX_W-1:0]      byte_index,
    input  logic [cfrf_pkg::BYTE_W-1:0]     start_byte,
    output logic                            wr_en,
    output logic [cfrf_pkg::ADDR_W-1:0]     wr_addr,
    output logic                            rd_en,
    output logic [cfrf_pkg::ADDR_W-1:0]     rd_addr,
    output cfrf_pkg::meta_t                 meta
);

    cfrf_pkg::rx_state_t             rx_state_reg, rx_state_next;
    logic [cfrf_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [cfrf_pkg::COUNT_W-1:0]    len_reg, len_next;
    logic [cfrf_pkg::SLOT_W-1:0]     head_reg, head_next;
    logic [cfrf_pkg::SLOT_W-1:0]     tail_reg, tail_next;
    logic [cfrf_pkg::SLOT_W-1:0]     head_inc, tail_inc;
    logic                            rx_go, empty, full, complete, lerr, remove_go;
    logic                            len_bad, len_zero, last_param;
    cfrf_pkg::op_t                   op_c;

    function automatic logic [cfrf_pkg::SLOT_W-1:0] slot_inc(
        input logic [cfrf_pkg::SLOT_W-1:0] s
    );
        if (s == cfrf_pkg::SLOT_W'(cfrf_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    function automatic cfrf_pkg::status_t status_of(
        input logic [cfrf_pkg::SLOT_W-1:0] h,
        input logic [cfrf_pkg::SLOT_W-1:0] t
    );
        if (h == t)
        begin
            return cfrf_pkg::ST_EMPTY;
        end
        if (h == slot_inc(t))
        begin
            return cfrf_pkg::ST_FULL;
        end
        return cfrf_pkg::ST_DATA;
    endfunction

    assign op_c     = cfrf_pkg::op_t'(op);
    assign rx_go    = acc && (op_c == cfrf_pkg::OP_RECEIVE);
    assign remove_go = acc && (op_c == cfrf_pkg::OP_REMOVE) && !empty;
    assign head_inc = slot_inc(head_reg);
    assign tail_inc = slot_inc(tail_reg);
    assign empty    = (head_reg == tail_reg);
    assign full     = (head_reg == tail_inc);
    assign len_bad  = (rx_byte > cfrf_pkg::BYTE_W'(cfrf_pkg::MAX_PARAMS));
    assign len_zero = (rx_byte == '0);
    assign last_param = (count_reg == len_reg + 1'b1);

    // receive FSM: next state
    always_comb
    begin
        rx_state_next = rx_state_reg;
        if (rx_go)
        begin
            unique case (rx_state_reg)
                cfrf_pkg::RX_HUNT:
                begin
                    if (rx_byte == start_byte)
                    begin
                        rx_state_next = cfrf_pkg::RX_CMD;
                    end
                end
                cfrf_pkg::RX_CMD:   rx_state_next = cfrf_pkg::RX_LEN;
                cfrf_pkg::RX_LEN:
                begin
                    if (len_bad || len_zero)
                    begin
                        rx_state_next = cfrf_pkg::RX_HUNT;
                    end
                    else
                    begin
                        rx_state_next = cfrf_pkg::RX_PARAM;
                    end
                end
                cfrf_pkg::RX_PARAM:
                begin
                    if (last_param)
                    begin
                        rx_state_next = cfrf_pkg::RX_HUNT;
                    end
                end
                default:            rx_state_next = cfrf_pkg::RX_HUNT;
            endcase
        end
    end

    // receive FSM: outputs
    always_comb
    begin
        wr_en      = 1'b0;
        complete   = 1'b0;
        lerr       = 1'b0;
        count_next = count_reg;
        len_next   = len_reg;
        if (rx_go)
        begin
            unique case (rx_state_reg)
                cfrf_pkg::RX_HUNT:
                begin
                    count_next = '0;
                end
                cfrf_pkg::RX_CMD:
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                cfrf_pkg::RX_LEN:
                begin
                    wr_en = 1'b1;
                    if (len_bad)
                    begin
                        lerr       = 1'b1;
                        count_next = '0;
                    end
                    else if (len_zero)
                    begin
                        complete   = 1'b1;
                        count_next = '0;
                    end
                    else
                    begin
                        len_next   = rx_byte[cfrf_pkg::COUNT_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                cfrf_pkg::RX_PARAM:
                begin
                    wr_en = 1'b1;
                    if (last_param)
                    begin
                        complete   = 1'b1;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    count_next = '0;
                end
            endcase
        end
    end

    // frame is built in place in the tail slot, which is always spare
    assign wr_addr = cfrf_pkg::ADDR_W'(tail_reg) * cfrf_pkg::ADDR_W'(cfrf_pkg::FRAME_BYTES)
                   + cfrf_pkg::ADDR_W'(count_reg);

    assign tail_next = (complete && !full) ? tail_inc : tail_reg;
    assign head_next = remove_go ? head_inc : head_reg;

    assign rd_en   = acc && (op_c == cfrf_pkg::OP_READ) && !empty
                   && (byte_index < cfrf_pkg::IDX_W'(cfrf_pkg::FRAME_BYTES));
    assign rd_addr = cfrf_pkg::ADDR_W'(head_reg) * cfrf_pkg::ADDR_W'(cfrf_pkg::FRAME_BYTES)
                   + cfrf_pkg::ADDR_W'(byte_index);

    always_comb
    begin
        meta.rd_use  = rd_en;
        meta.status  = status_of(head_next, tail_next);
        meta.queued  = complete && !full;
        meta.dropped = complete && full;
        meta.lerr    = lerr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_state_reg <= cfrf_pkg::RX_HUNT;
            count_reg    <= '0;
            len_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
        end
        else
        begin
            rx_state_reg <= rx_state_next;
            count_reg    <= count_next;
            len_reg      <= len_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

endmodule

// File: hdl/cfrf_out_stage.sv
module cfrf_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            acc,
    input  cfrf_pkg::meta_t                 meta,
    input  logic [cfrf_pkg::BYTE_W-1:0]     rd_data,
    output logic                            in_ready,
    cfrf_out_if.source                      result
);

    logic                           s1_valid_reg;
    cfrf_pkg::meta_t                s1_meta_reg;
    logic                           out_valid_reg;
    logic [cfrf_pkg::BYTE_W-1:0]    data_reg;
    cfrf_pkg::status_t              status_reg;
    logic                           queued_reg, dropped_reg, lerr_reg;
    logic                           s1_adv;

    // stage 1 waits on the memory read; output register parts the two sides
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || result.ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_meta_reg <= meta;
        end
        if (s1_adv)
        begin
            data_reg    <= s1_meta_reg.rd_use ? rd_data : '0;
            status_reg  <= s1_meta_reg.status;
            queued_reg  <= s1_meta_reg.queued;
            dropped_reg <= s1_meta_reg.dropped;
            lerr_reg    <= s1_meta_reg.lerr;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.read_data     = data_reg;
    assign result.queue_status  = status_reg;
    assign result.frame_queued  = queued_reg;
    assign result.frame_dropped = dropped_reg;
    assign result.length_error  = lerr_reg;

endmodule

// File: hdl/cfrf_checker.sv
module cfrf_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [cfrf_pkg::BYTE_W-1:0]      read_data,
    input logic [cfrf_pkg::STAT_W-1:0]      queue_status,
    input logic                             frame_queued,
    input logic                             frame_dropped,
    input logic                             length_error
);

    // stalled transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
        && $stable({read_data, queue_status, frame_queued, frame_dropped, length_error}))
        else $error("result changed while stalled");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({frame_queued, frame_dropped, length_error}) <= 1)
        else $error("more than one frame event flagged");

    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_status == cfrf_pkg::ST_EMPTY |-> read_data == '0)
        else $error("nonzero read data from empty queue");

    a_queued_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_queued |-> queue_status != cfrf_pkg::ST_EMPTY)
        else $error("queued frame but queue reports empty");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_dropped |-> queue_status == cfrf_pkg::ST_FULL)
        else $error("dropped frame while queue not full");

endmodule

bind command_frame_receiver_fifo_core cfrf_checker u_cfrf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .read_data     (result.read_data),
    .queue_status  (result.queue_status),
    .frame_queued  (result.frame_queued),
    .frame_dropped (result.frame_dropped),
    .length_error  (result.length_error)
);
